>>> hdl/sha1hx_pkg.sv
// ----------------------------------------------------------------------------
// sha1hx_pkg: shared types and constants of the per-line SHA-1 hex hasher
// Payload structs, SHA-1 constants, controller command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package sha1hx_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] RETURN_CODE  = 8'd13;
   localparam logic [7:0] PAD_CODE     = 8'h80;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;

   // Block positions and digit slots
   localparam logic [5:0] BLOCK_LAST = 6'd63;  // last byte of a block
   localparam logic [5:0] DATA_LAST  = 6'd55;  // last byte before the length field
   localparam logic [5:0] LAST_DIGIT = 6'd39;  // final hex digit of a digest
   localparam logic [5:0] NL_SLOT    = 6'd40;  // slot of the trailing newline

   // Buffer write source
   typedef enum logic [1:0] {
      WSRC_BYTE,
      WSRC_RETURN,
      WSRC_PAD,
      WSRC_ZERO
   } wsrc_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       buf_wr;      // write one byte into the block buffer
      wsrc_type   wsrc;
      logic       len_inc;     // advance the line length by one byte
      logic       len_wr;      // write the length bytes instead of wsrc
      logic       start_comp;  // start a compression run
      logic       line_init;   // reset chain, length and write position
      logic [5:0] digit_idx;   // digit selected for output (0..39)
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [5:0] fill_idx;    // next byte position in the block
      logic       comp_busy;
   } sts_type;

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) r = 8'h30 + {4'd0, v};
      else           r = 8'h37 + {4'd0, v};
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/per_line_sha1_hex_hasher.sv
// Sequence: a byte is accepted and then written into the buffer, after a held return
// if any; a byte that fills a block adds a compression (80 rounds, chain update, exit).
// Line end: padding writes one byte per cycle to the block end, pausing for each
// compression (an extra block when the pad byte lands past byte 55), then the last
// compression runs, then 40 or 41 output transfers, one per cycle while rsp_ready is high.
// Reset: synchronous; clears state, length and chain to the SHA-1 initial values.
// ----------------------------------------------------------------------------
// per_line_sha1_hex_hasher: SHA-1 digest of each text line as uppercase hex
// Controller sequences byte absorb, padding and output; datapath hashes.
// ----------------------------------------------------------------------------
`default_nettype none
module per_line_sha1_hex_hasher
   import sha1hx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type    cmd;
   sts_type    sts;
   logic [3:0] digit;
   logic [7:0] byte_q;

   sha1hx_control u_control (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .cmd, .sts, .digit,
      .byte_out(byte_q)
   );

   sha1hx_datapath u_datapath (
      .clock, .reset, .in_byte(byte_q), .cmd, .sts, .digit
   );

endmodule
`default_nettype wire

>>> hdl/sha1hx_datapath.sv
// ----------------------------------------------------------------------------
// sha1hx_datapath: block buffer, length counter and SHA-1 round engine
// One round per cycle; a compression runs 80 rounds and then one chain update.
// ----------------------------------------------------------------------------
`default_nettype none
module sha1hx_datapath
   import sha1hx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] in_byte,
   input  wire cmd_type    cmd,
   output sts_type         sts,
   output logic [3:0]      digit
);

   logic [63:0] len_ff;
   logic [5:0]  ptr_ff;
   logic [31:0] h_ff [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] w_ff [16];
   logic [6:0]  t_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [7:0]  wr_data;
   logic [31:0] w_mix, w_new, f, k, tmp;
   logic [2:0]  word_sel;
   logic [31:0] dw;

   // Select the byte written into the buffer
   always_comb begin
      case (cmd.wsrc)
         WSRC_BYTE:   wr_data = in_byte;
         WSRC_RETURN: wr_data = RETURN_CODE;
         WSRC_PAD:    wr_data = PAD_CODE;
         default:     wr_data = 8'd0;
      endcase
      if (cmd.len_wr) wr_data = len_ff[{~ptr_ff[2:0], 3'b000} +: 8];
   end

   // Round logic; the 16 words hold the block and then the message schedule
   assign w_mix = w_ff[t_ff[3:0] + 4'd13] ^ w_ff[t_ff[3:0] + 4'd8]
                ^ w_ff[t_ff[3:0] + 4'd2] ^ w_ff[t_ff[3:0]];
   assign w_new = (t_ff < 7'd16) ? w_ff[t_ff[3:0]] : {w_mix[30:0], w_mix[31]};
   always_comb begin
      if (t_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = 32'h5A827999;
      end else if (t_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = 32'h6ED9EBA1;
      end else if (t_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = 32'h8F1BBCDC;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = 32'hCA62C1D6;
      end
   end
   assign tmp = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + w_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0; ptr_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0; t_ff <= '0;
         h_ff[0] <= H0; h_ff[1] <= H1; h_ff[2] <= H2; h_ff[3] <= H3; h_ff[4] <= H4;
      end else begin
         done_ff <= 1'b0;
         // Line length and write position
         if (cmd.line_init) begin
            len_ff <= '0; ptr_ff <= '0;
         end else begin
            if (cmd.len_inc) len_ff <= len_ff + 64'd8;
            if (cmd.buf_wr)  ptr_ff <= ptr_ff + 6'd1;
         end
         // Chain: restart per line, accumulate after each compression
         if (cmd.line_init) begin
            h_ff[0] <= H0; h_ff[1] <= H1; h_ff[2] <= H2; h_ff[3] <= H3; h_ff[4] <= H4;
         end else if (done_ff) begin
            h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
            h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
            h_ff[4] <= h_ff[4] + e_ff;
         end
         // Round engine
         if (cmd.start_comp) begin
            busy_ff <= 1'b1; t_ff <= '0;
            a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
            d_ff <= h_ff[3]; e_ff <= h_ff[4];
         end else if (busy_ff) begin
            a_ff <= tmp; b_ff <= a_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
            d_ff <= c_ff; e_ff <= d_ff;
            t_ff <= t_ff + 7'd1;
            if (t_ff == 7'd79) begin
               busy_ff <= 1'b0; done_ff <= 1'b1;
            end
         end
         // Block words: byte writes while idle, schedule writes while running
         if (busy_ff) w_ff[t_ff[3:0]] <= w_new;
         else if (cmd.buf_wr) w_ff[ptr_ff[5:2]][{~ptr_ff[1:0], 3'b000} +: 8] <= wr_data;
      end
   end

   // Output digit selection
   assign word_sel = (cmd.digit_idx[5:3] > 3'd4) ? 3'd4 : cmd.digit_idx[5:3];
   assign dw       = h_ff[word_sel];
   assign digit    = dw[{~cmd.digit_idx[2:0], 2'b00} +: 4];

   assign sts.fill_idx  = ptr_ff;
   assign sts.comp_busy = busy_ff || done_ff;

endmodule
`default_nettype wire

>>> hdl/sha1hx_control.sv
// ----------------------------------------------------------------------------
// sha1hx_control: sequencer for absorb, padding and hex output
// Takes one input byte, drives buffer writes, padding and digit emission.
// ----------------------------------------------------------------------------
`default_nettype none
module sha1hx_control
   import sha1hx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   output cmd_type      cmd,
   input  wire sts_type sts,
   input  wire logic [3:0] digit,
   output logic [7:0]   byte_out
);

   typedef enum logic [3:0] {
      S_IDLE, S_RET, S_BYTE, S_WAITC, S_PAD, S_ZERO, S_LEN, S_OUT
   } state_type;

   state_type   state_ff;
   state_type   after_ff;
   logic [7:0]  byte_ff;
   logic        eoi_ff, nl_ff, pend_ff;
   logic [5:0]  didx_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign byte_out  = byte_ff;

   // Result: digits, then the newline when the line ended with one
   always_comb begin
      rsp_valid = (state_ff == S_OUT);
      rsp_data.out_byte = (didx_ff == NL_SLOT) ? NEWLINE_CODE : hex_char(digit);
      rsp_data.last_of_run = (didx_ff == NL_SLOT) || (didx_ff == LAST_DIGIT && !nl_ff);
   end

   // Datapath commands
   always_comb begin
      cmd = '0;
      cmd.digit_idx = didx_ff;
      case (state_ff)
         S_RET: begin
            cmd.buf_wr = 1'b1; cmd.wsrc = WSRC_RETURN;
            cmd.len_inc = 1'b1; cmd.start_comp = (sts.fill_idx == BLOCK_LAST);
         end
         S_BYTE: if (byte_ff != RETURN_CODE) begin
            cmd.buf_wr = 1'b1; cmd.wsrc = WSRC_BYTE;
            cmd.len_inc = 1'b1; cmd.start_comp = (sts.fill_idx == BLOCK_LAST);
         end
         S_PAD: begin
            cmd.buf_wr = 1'b1; cmd.wsrc = WSRC_PAD;
            cmd.start_comp = (sts.fill_idx == BLOCK_LAST);
         end
         S_ZERO: begin
            cmd.buf_wr = 1'b1; cmd.wsrc = WSRC_ZERO;
            cmd.start_comp = (sts.fill_idx == BLOCK_LAST);
         end
         S_LEN: begin
            cmd.buf_wr = 1'b1; cmd.len_wr = 1'b1;
            cmd.start_comp = (sts.fill_idx == BLOCK_LAST);
         end
         S_OUT: cmd.line_init = rsp_ready && rsp_data.last_of_run;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; after_ff <= S_IDLE; byte_ff <= '0;
         eoi_ff <= 1'b0; nl_ff <= 1'b0; pend_ff <= 1'b0; didx_ff <= '0;
      end else begin
         case (state_ff)
            // Take a byte; a newline drops any held return and ends the line
            S_IDLE: if (req_valid) begin
               byte_ff <= req_data.data_byte;
               eoi_ff  <= req_data.end_of_input;
               if (req_data.data_byte == NEWLINE_CODE) begin
                  pend_ff <= 1'b0; nl_ff <= 1'b1; state_ff <= S_PAD;
               end else if (pend_ff) begin
                  pend_ff <= 1'b0; state_ff <= S_RET;
               end else begin
                  state_ff <= S_BYTE;
               end
            end
            // Write the held return, then the byte itself
            S_RET: begin
               after_ff <= S_BYTE;
               state_ff <= (sts.fill_idx == BLOCK_LAST) ? S_WAITC : S_BYTE;
            end
            // Absorb the byte, or hold a return until the next byte
            S_BYTE: begin
               pend_ff  <= (byte_ff == RETURN_CODE) && !eoi_ff;
               nl_ff    <= 1'b0;
               after_ff <= eoi_ff ? S_PAD : S_IDLE;
               if (byte_ff != RETURN_CODE && sts.fill_idx == BLOCK_LAST) state_ff <= S_WAITC;
               else state_ff <= eoi_ff ? S_PAD : S_IDLE;
            end
            S_WAITC: if (!sts.comp_busy) state_ff <= after_ff;
            S_PAD: begin
               if (sts.fill_idx == BLOCK_LAST) begin
                  after_ff <= S_ZERO; state_ff <= S_WAITC;
               end else if (sts.fill_idx == DATA_LAST) state_ff <= S_LEN;
               else state_ff <= S_ZERO;
            end
            S_ZERO: begin
               if (sts.fill_idx == BLOCK_LAST) begin
                  after_ff <= S_ZERO; state_ff <= S_WAITC;
               end else if (sts.fill_idx == DATA_LAST) state_ff <= S_LEN;
            end
            S_LEN: if (sts.fill_idx == BLOCK_LAST) begin
               after_ff <= S_OUT; didx_ff <= '0; state_ff <= S_WAITC;
            end
            // Advance one digit per transfer
            S_OUT: if (rsp_ready) begin
               if (rsp_data.last_of_run) begin
                  didx_ff <= '0; state_ff <= S_IDLE;
               end else didx_ff <= didx_ff + 6'd1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the per-line SHA-1 hex hasher
// Drives text bytes over the request channel, computes each line's SHA-1
// digest in a local model and checks every hex digit and newline returned.
// ----------------------------------------------------------------------------
`default_nettype none
module tb
   import sha1hx_pkg::*;
();

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   per_line_sha1_hex_hasher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // model state of the hasher
   logic [31:0] chain [5];
   logic [7:0]  blk [64];
   logic [31:0] sched [16];
   logic [63:0] bit_len;
   logic        cr_held;

   rsp_type digest_queue [$];
   int      errors;
   int      cycles;
   int      lines_sent;
   int      bytes_sent;
   int      digits_seen;
   int      send_idle_pct;
   int      recv_idle_pct;

   localparam int CYCLE_LIMIT = 2000000;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // one SHA-1 compression of the block buffer into the chain
   task automatic compress();
      logic [31:0] a, b, c, d, e, w, f, k, tmp;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int t = 0; t < 80; t++) begin
         if (t < 16) begin
            w = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
         end else begin
            w = rotl(sched[(t-3)&15] ^ sched[(t-8)&15] ^ sched[(t-14)&15] ^ sched[t&15], 1);
         end
         sched[t&15] = w;
         if (t < 20) begin
            f = (b & c) | (~b & d); k = 32'h5A827999;
         end else if (t < 40) begin
            f = b ^ c ^ d; k = 32'h6ED9EBA1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d; k = 32'hCA62C1D6;
         end
         tmp = rotl(a, 5) + f + e + k + w;
         e = d; d = c; c = rotl(b, 30); b = a; a = tmp;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
   endtask

   task automatic line_restart();
      chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
      bit_len = '0;
   endtask

   task automatic absorb(input logic [7:0] v);
      int idx;
      idx = int'(bit_len[8:3]);
      blk[idx] = v;
      bit_len += 64'd8;
      if (idx == 63) compress();
   endtask

   function automatic logic [7:0] to_hex(input logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h37 + {4'd0, v};
   endfunction

   // pad, finish the digest and queue its hex digits
   task automatic finish_line(input logic with_nl);
      int      idx;
      logic [7:0] v;
      rsp_type r;
      idx = int'(bit_len[8:3]);
      blk[idx] = PAD_CODE;
      idx++;
      if (idx > 56) begin
         while (idx < 64) begin blk[idx] = 8'd0; idx++; end
         compress();
         idx = 0;
      end
      while (idx < 56) begin blk[idx] = 8'd0; idx++; end
      for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
      compress();
      for (int i = 0; i < 20; i++) begin
         v = chain[i>>2][31-8*(i&3) -: 8];
         r.out_byte = to_hex(v[7:4]); r.last_of_run = 1'b0;
         digest_queue = {digest_queue, r};
         r.out_byte = to_hex(v[3:0]);
         r.last_of_run = (i == 19) && !with_nl;
         digest_queue = {digest_queue, r};
      end
      if (with_nl) begin
         r.out_byte = NEWLINE_CODE; r.last_of_run = 1'b1;
         digest_queue = {digest_queue, r};
      end
      lines_sent++;
      line_restart();
   endtask

   task automatic predict_byte(input req_type q);
      if (q.data_byte == NEWLINE_CODE) begin
         cr_held = 1'b0;
         finish_line(1'b1);
         return;
      end
      if (cr_held) begin
         absorb(RETURN_CODE);
         cr_held = 1'b0;
      end
      if (q.data_byte == RETURN_CODE) cr_held = 1'b1;
      else absorb(q.data_byte);
      if (q.end_of_input) begin
         cr_held = 1'b0;
         finish_line(1'b0);
      end
   endtask

   // send one byte; expectation is built when the transfer happens
   task automatic send_byte(input logic [7:0] b, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, end_of_input: eoi};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte('{data_byte: b, end_of_input: eoi});
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic eoi_last);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], eoi_last && i == s.len() - 1);
   endtask

   // hold the sender until every expected result has come
   task automatic drain();
      req_valid <= 1'b0;
      while (digest_queue.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   // check each result against the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         cycles <= cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               $error("unexpected result out_byte=%h last_of_run=%b",
                      rsp_data.out_byte, rsp_data.last_of_run);
               errors++;
            end else begin
               if (rsp_data.out_byte !== digest_queue[0].out_byte) begin
                  $error("out_byte expected %h actual %h",
                         digest_queue[0].out_byte, rsp_data.out_byte);
                  errors++;
               end
               if (rsp_data.last_of_run !== digest_queue[0].last_of_run) begin
                  $error("last_of_run expected %b actual %b",
                         digest_queue[0].last_of_run, rsp_data.last_of_run);
                  errors++;
               end
               void'(digest_queue.pop_front());
               digits_seen++;
            end
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // empty lines, CR handling, end of input variants
   task automatic test_line_endings();
      send_text("\n", 1'b0);
      send_text("abc\n", 1'b0);
      send_text("abc\r\n", 1'b0);
      send_text("a\rb\n", 1'b0);
      send_text("\r\r\n", 1'b0);
      send_text("xy\r", 1'b1);
      send_text("q\n", 1'b1);
      send_text("z", 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(RETURN_CODE, 1'b1);
      drain();
   endtask

   // lines crossing the 55/56/64 byte padding boundaries
   task automatic test_block_boundaries();
      int lens [4] = '{55, 56, 63, 64};
      foreach (lens[j]) begin
         for (int i = 0; i < lens[j]; i++) send_byte(8'h20 + 8'(i % 90), 1'b0);
         send_byte(NEWLINE_CODE, 1'b0);
      end
      drain();
   endtask

   // random text lines with noise bytes and stray CRs
   task automatic test_random_text(input int n_bytes);
      logic [7:0] b;
      int r;
      for (int i = 0; i < n_bytes; i++) begin
         r = $urandom_range(99);
         if (r < 10) b = NEWLINE_CODE;
         else if (r < 16) b = RETURN_CODE;
         else if (r < 30) b = 8'($urandom_range(255));
         else b = 8'($urandom_range(126, 32));
         send_byte(b, $urandom_range(99) < 2);
      end
      send_byte(NEWLINE_CODE, 1'b0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      lines_sent = 0; bytes_sent = 0;
      send_idle_pct = 13; recv_idle_pct = 86;
      cr_held = 1'b0;
      line_restart();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_line_endings();
      test_block_boundaries();
      test_random_text(70);
      drain();
      send_idle_pct = 86; recv_idle_pct = 13;
      test_random_text(60);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random_text(60);
      drain();

      $display("Hashed %0d lines from %0d bytes, %0d output bytes checked.",
               lines_sent, bytes_sent, digits_seen);
      $display("Covered CR handling, block padding boundaries and random text.");
      if (errors == 0 && digest_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
